FILE: src/mlmeu_pkg.sv
// ----------------------------------------------------------------------------
// MCA list-mode event unpacker package
// Shared widths, codes and the record type passed from the word classifier
// to the result sequencer.
// ----------------------------------------------------------------------------
package mlmeu_pkg;

  // Default and field widths
  localparam int unsigned NUM_CONVERTERS_DEF = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned MULT_W     = 5;
  localparam int unsigned CNT_W      = 64;
  localparam int unsigned ACT_W      = 5;
  localparam int unsigned DSCALE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CONVERTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_DOWNSCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_HALF_FIRST    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [ACT_W-1:0]    ACTIVE_RESET    = 5'd16;
  localparam logic [DSCALE_W-1:0] DOWNSCALE_RESET = 16'd1;

  // Header word decoding
  localparam logic [WORD_W-1:0] SYNC_WORD = 32'hFFFF_FFFF;
  localparam int unsigned       TICK_BIT  = 30;
  localparam int unsigned       DUMMY_BIT = 31;

  // Queue between classifier and sequencer
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_SYNC  = 2'd2,
    KIND_ERROR = 2'd3
  } item_kind_e;

  typedef enum logic {
    ERR_NO_TRIGGER   = 1'b0,
    ERR_ODD_NO_DUMMY = 1'b1
  } error_code_e;

  // One converter value
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [HALF_W-1:0] value;
    logic              last;
  } conv_val_t;

  // One queued request: all results caused by one stream word
  typedef struct packed {
    item_kind_e        kind;
    error_code_e       err;
    logic [MULT_W-1:0] mult;
    logic [CNT_W-1:0]  ticks;
    logic [CNT_W-1:0]  elapsed;
    logic              two;
    conv_val_t         first;
    conv_val_t         second;
  } entry_t;

  // Queue status: full for the writing side, valid for the sequencer side
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

FILE: src/mca_list_mode_event_unpacker_top.sv
// Path: an accepted word with results is written into the request queue, then
// loaded into the output register. Throughput: one stream word per cycle into
// the classifier while the queue has room; one result per cycle out of the
// sequencer while pop is high and results wait, so a word with two values holds
// the register until both are popped, while the four-entry queue absorbs input.
// Reset: asynchronous, clears the event state, counters and queue, and loads
// the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// MCA list-mode event unpacker, top level
// Classifier, request queue and result sequencer for a list-mode word stream.
// ----------------------------------------------------------------------------
module mca_list_mode_event_unpacker_top #(
  parameter int unsigned NUM_CONVERTERS = mlmeu_pkg::NUM_CONVERTERS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [mlmeu_pkg::WORD_W-1:0]       stream_word_i,
  input  logic                               cfg_we_i,
  input  logic [mlmeu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mlmeu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         item_kind_o,
  output logic                               error_code_o,
  output logic [mlmeu_pkg::IDX_W-1:0]        converter_index_o,
  output logic [mlmeu_pkg::HALF_W-1:0]       converter_value_o,
  output logic [mlmeu_pkg::MULT_W-1:0]       event_multiplicity_o,
  output logic [mlmeu_pkg::CNT_W-1:0]        tick_count_o,
  output logic [mlmeu_pkg::CNT_W-1:0]        elapsed_ms_o,
  output logic                               last_of_event_o
);

  logic                 accept;
  logic                 entry_valid;
  mlmeu_pkg::entry_t    entry;
  mlmeu_pkg::entry_t    q_entry;
  mlmeu_pkg::q_status_t q_status;
  logic                 q_rd;

  // Accept a request when the queue has room
  assign accept = push && !q_status.full;
  assign full   = q_status.full;

  mlmeu_front #(
    .NUM_CONVERTERS(NUM_CONVERTERS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .word_i       (stream_word_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .entry_valid_o(entry_valid),
    .entry_o      (entry)
  );

  mlmeu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (entry_valid),
    .wr_entry_i(entry),
    .rd_i      (q_rd),
    .rd_entry_o(q_entry),
    .status_o  (q_status)
  );

  mlmeu_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_status_i          (q_status),
    .q_entry_i           (q_entry),
    .q_rd_o              (q_rd),
    .pop_i               (pop),
    .empty_o             (empty),
    .item_kind_o         (item_kind_o),
    .error_code_o        (error_code_o),
    .converter_index_o   (converter_index_o),
    .converter_value_o   (converter_value_o),
    .event_multiplicity_o(event_multiplicity_o),
    .tick_count_o        (tick_count_o),
    .elapsed_ms_o        (elapsed_ms_o),
    .last_of_event_o     (last_of_event_o)
  );

endmodule

FILE: src/mlmeu_front.sv
// ----------------------------------------------------------------------------
// MCA list-mode word classifier
// Accepts stream words, decodes headers, tracks the open event and the
// timer counters, and forms one queue request per word that yields results.
// ----------------------------------------------------------------------------
module mlmeu_front #(
  parameter int unsigned NUM_CONVERTERS = mlmeu_pkg::NUM_CONVERTERS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [mlmeu_pkg::WORD_W-1:0]         word_i,
  input  logic                                 cfg_we_i,
  input  logic [mlmeu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mlmeu_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                 entry_valid_o,
  output mlmeu_pkg::entry_t                    entry_o
);

  localparam int unsigned NC = NUM_CONVERTERS;

  // Configuration registers
  logic [mlmeu_pkg::ACT_W-1:0]    active_q;
  logic [mlmeu_pkg::DSCALE_W-1:0] downscale_q;
  logic                           low_first_q;

  // Event and counter state
  logic                           in_event_q, in_event_d;
  logic [NC-1:0]                  pend_q, pend_d;
  logic                           skip_q, skip_d;
  logic [mlmeu_pkg::MULT_W-1:0]   mult_q, mult_d;
  logic [mlmeu_pkg::CNT_W-1:0]    ticks_q, ticks_d;
  logic [mlmeu_pkg::CNT_W-1:0]    elapsed_q, elapsed_d;

  logic [mlmeu_pkg::ACT_W-1:0]    act_sat;
  logic [NC-1:0]                  hdr_mask;
  logic [mlmeu_pkg::MULT_W-1:0]   hdr_cnt;
  logic [mlmeu_pkg::HALF_W-1:0]   half_a, half_b;
  logic [NC-1:0]                  pm1, pm2;
  logic [mlmeu_pkg::IDX_W-1:0]    ia, ib;

  // Lowest set bit of a converter mask
  function automatic logic [mlmeu_pkg::IDX_W-1:0] lowest_idx(input logic [NC-1:0] m);
    logic [mlmeu_pkg::IDX_W-1:0] r;
    r = '0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (m[i]) r = mlmeu_pkg::IDX_W'(i);
    end
    return r;
  endfunction

  // Header mask limited to the active converters
  always_comb begin
    act_sat = (active_q > mlmeu_pkg::ACT_W'(NC)) ? mlmeu_pkg::ACT_W'(NC) : active_q;
    for (int i = 0; i < NC; i++) begin
      hdr_mask[i] = word_i[i] & (mlmeu_pkg::ACT_W'(i) < act_sat);
    end
    hdr_cnt = mlmeu_pkg::MULT_W'($countones(hdr_mask));
  end

  // Halfword order and the next two converters to serve
  always_comb begin
    half_a = low_first_q ? word_i[15:0] : word_i[31:16];
    half_b = low_first_q ? word_i[31:16] : word_i[15:0];
    ia     = lowest_idx(pend_q);
    pm1    = pend_q & ~(NC'(1) << ia);
    ib     = lowest_idx(pm1);
    pm2    = pm1 & ~(NC'(1) << ib);
  end

  // Classify the accepted word and form its request
  always_comb begin
    in_event_d    = in_event_q;
    pend_d        = pend_q;
    skip_d        = skip_q;
    mult_d        = mult_q;
    ticks_d       = ticks_q;
    elapsed_d     = elapsed_q;
    entry_valid_o = 1'b0;
    entry_o       = '0;
    entry_o.kind  = mlmeu_pkg::KIND_VALUE;
    entry_o.err   = mlmeu_pkg::ERR_NO_TRIGGER;
    entry_o.ticks   = ticks_q;
    entry_o.elapsed = elapsed_q;
    if (accept_i) begin
      if (!in_event_q) begin
        if (word_i == mlmeu_pkg::SYNC_WORD) begin
          entry_valid_o = 1'b1;
          entry_o.kind  = mlmeu_pkg::KIND_SYNC;
        end else if (word_i[mlmeu_pkg::TICK_BIT]) begin
          ticks_d         = ticks_q + mlmeu_pkg::CNT_W'(1);
          elapsed_d       = elapsed_q + mlmeu_pkg::CNT_W'(downscale_q);
          entry_valid_o   = 1'b1;
          entry_o.kind    = mlmeu_pkg::KIND_TICK;
          entry_o.ticks   = ticks_d;
          entry_o.elapsed = elapsed_d;
        end else if (hdr_cnt == '0) begin
          entry_valid_o = 1'b1;
          entry_o.kind  = mlmeu_pkg::KIND_ERROR;
          entry_o.err   = mlmeu_pkg::ERR_NO_TRIGGER;
        end else if (hdr_cnt[0] && !word_i[mlmeu_pkg::DUMMY_BIT]) begin
          entry_valid_o = 1'b1;
          entry_o.kind  = mlmeu_pkg::KIND_ERROR;
          entry_o.err   = mlmeu_pkg::ERR_ODD_NO_DUMMY;
          entry_o.mult  = hdr_cnt;
        end else begin
          in_event_d = 1'b1;
          pend_d     = hdr_mask;
          skip_d     = hdr_cnt[0];
          mult_d     = hdr_cnt;
        end
      end else if (pend_q == '0) begin
        // Nothing left to serve: close the event
        in_event_d = 1'b0;
        skip_d     = 1'b0;
      end else begin
        entry_valid_o = 1'b1;
        entry_o.mult  = mult_q;
        if (skip_q) begin
          // Drop the dummy halfword, serve one value from the second half
          skip_d         = 1'b0;
          entry_o.first  = '{idx: ia, value: half_b, last: (pm1 == '0)};
          pend_d         = pm1;
          in_event_d     = (pm1 != '0);
        end else begin
          entry_o.first = '{idx: ia, value: half_a, last: (pm1 == '0)};
          if (pm1 != '0) begin
            entry_o.two    = 1'b1;
            entry_o.second = '{idx: ib, value: half_b, last: (pm2 == '0)};
            pend_d         = pm2;
            in_event_d     = (pm2 != '0);
          end else begin
            pend_d     = pm1;
            in_event_d = 1'b0;
          end
        end
      end
    end
  end

  // Hold configuration and event state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= mlmeu_pkg::ACTIVE_RESET;
      downscale_q <= mlmeu_pkg::DOWNSCALE_RESET;
      low_first_q <= 1'b1;
      in_event_q  <= 1'b0;
      pend_q      <= '0;
      skip_q      <= 1'b0;
      mult_q      <= '0;
      ticks_q     <= '0;
      elapsed_q   <= '0;
    end else begin
      in_event_q <= in_event_d;
      pend_q     <= pend_d;
      skip_q     <= skip_d;
      mult_q     <= mult_d;
      ticks_q    <= ticks_d;
      elapsed_q  <= elapsed_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == mlmeu_pkg::CFG_ACTIVE_CONVERTERS) begin
          active_q <= cfg_data_i[mlmeu_pkg::ACT_W-1:0];
        end
        if (cfg_idx_i == mlmeu_pkg::CFG_TIMER_DOWNSCALE) begin
          downscale_q <= cfg_data_i[mlmeu_pkg::DSCALE_W-1:0];
        end
        if (cfg_idx_i == mlmeu_pkg::CFG_LOW_HALF_FIRST) begin
          low_first_q <= cfg_data_i[0];
        end
      end
    end
  end

endmodule

FILE: src/mlmeu_queue.sv
// ----------------------------------------------------------------------------
// MCA list-mode request queue
// Short first-in first-out buffer between the word classifier and the
// result sequencer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module mlmeu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  mlmeu_pkg::entry_t    wr_entry_i,
  input  logic                 rd_i,
  output mlmeu_pkg::entry_t    rd_entry_o,
  output mlmeu_pkg::q_status_t status_o
);

  mlmeu_pkg::entry_t                mem_q [mlmeu_pkg::QUEUE_DEPTH];
  logic [mlmeu_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [mlmeu_pkg::QPTR_W:0]       count_q, count_d;
  logic                             do_wr, do_rd;

  // Qualify requests against occupancy
  always_comb begin
    status_o.full  = (count_q == (mlmeu_pkg::QPTR_W + 1)'(mlmeu_pkg::QUEUE_DEPTH));
    status_o.valid = (count_q != '0);
    do_wr          = wr_i && !status_o.full;
    do_rd          = rd_i && status_o.valid;
    count_d        = count_q;
    if (do_wr && !do_rd) count_d = count_q + 1'b1;
    if (!do_wr && do_rd) count_d = count_q - 1'b1;
    rd_entry_o     = mem_q[rd_ptr_q];
  end

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_entry_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

endmodule

FILE: src/mlmeu_back.sv
// ----------------------------------------------------------------------------
// MCA list-mode result sequencer
// Takes queued requests into an output register and presents their one or
// two results in order, one per pop.
// ----------------------------------------------------------------------------
module mlmeu_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mlmeu_pkg::q_status_t               q_status_i,
  input  mlmeu_pkg::entry_t                  q_entry_i,
  output logic                               q_rd_o,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic [1:0]                         item_kind_o,
  output logic                               error_code_o,
  output logic [mlmeu_pkg::IDX_W-1:0]        converter_index_o,
  output logic [mlmeu_pkg::HALF_W-1:0]       converter_value_o,
  output logic [mlmeu_pkg::MULT_W-1:0]       event_multiplicity_o,
  output logic [mlmeu_pkg::CNT_W-1:0]        tick_count_o,
  output logic [mlmeu_pkg::CNT_W-1:0]        elapsed_ms_o,
  output logic                               last_of_event_o
);

  mlmeu_pkg::entry_t    cur_q;
  logic                 out_valid_q;
  logic                 sel_q;
  logic                 last_sub, take, load;
  mlmeu_pkg::conv_val_t cv;

  // Decide when to advance within a request or take the next one
  always_comb begin
    last_sub = !cur_q.two || sel_q;
    take     = pop_i && out_valid_q;
    load     = q_status_i.valid && (!out_valid_q || (take && last_sub));
    q_rd_o   = load;
    empty_o  = !out_valid_q;
  end

  // Hold the current request
  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_entry_i;
  end

  // Track output valid and which result of the request is shown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      sel_q       <= 1'b0;
    end else if (take) begin
      if (last_sub) out_valid_q <= 1'b0;
      else sel_q <= 1'b1;
    end
  end

  // Drive result fields
  always_comb begin
    cv                   = sel_q ? cur_q.second : cur_q.first;
    item_kind_o          = cur_q.kind;
    error_code_o         = cur_q.err;
    converter_index_o    = cv.idx;
    converter_value_o    = cv.value;
    event_multiplicity_o = cur_q.mult;
    tick_count_o         = cur_q.ticks;
    elapsed_ms_o         = cur_q.elapsed;
    last_of_event_o      = cv.last;
  end

endmodule

FILE: src/mlmeu_checker.sv
// ----------------------------------------------------------------------------
// MCA list-mode event unpacker port checker
// Watches the top-level ports for ordering and hold rules of the results.
// ----------------------------------------------------------------------------
module mlmeu_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic [1:0]                         item_kind_o,
  input logic                               error_code_o,
  input logic [mlmeu_pkg::IDX_W-1:0]        converter_index_o,
  input logic [mlmeu_pkg::HALF_W-1:0]       converter_value_o,
  input logic [mlmeu_pkg::MULT_W-1:0]       event_multiplicity_o,
  input logic [mlmeu_pkg::CNT_W-1:0]        tick_count_o,
  input logic [mlmeu_pkg::CNT_W-1:0]        elapsed_ms_o,
  input logic                               last_of_event_o
);

  logic out_acc;
  assign out_acc = pop && !empty;

  // Hold a waiting result until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(item_kind_o) && $stable(converter_index_o)
                          && $stable(converter_value_o) && $stable(last_of_event_o)
                          && $stable(error_code_o) && $stable(elapsed_ms_o)))
    else $error("result changed while waiting");

  // Reset leaves both sides idle
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queue not idle in reset");

  // Values of an event that is not finished continue in ascending order
  a_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && item_kind_o == mlmeu_pkg::KIND_VALUE && !last_of_event_o) ##1 out_acc
    |-> (item_kind_o == mlmeu_pkg::KIND_VALUE
         && event_multiplicity_o == $past(event_multiplicity_o)
         && converter_index_o > $past(converter_index_o)))
    else $error("event values out of order");

  // Back-to-back ticks count by one
  a_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && item_kind_o == mlmeu_pkg::KIND_TICK) ##1
    (out_acc && item_kind_o == mlmeu_pkg::KIND_TICK)
    |-> (tick_count_o == $past(tick_count_o) + 64'd1))
    else $error("tick count skipped");

endmodule

bind mca_list_mode_event_unpacker_top mlmeu_checker u_checker (.*);

FILE: sim/tb_mca_list_mode_event_unpacker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MCA list-mode event unpacker testbench
// Feeds list-mode words through the push/full side under random bursts and
// gaps, drains results through empty/pop with changing stall patterns, and
// checks every result field against an in-bench unpacker model. Runs a
// directed set of header, tick, sync and event words, then random
// well-formed events mixed with noise and broken headers across several
// register settings.
// ----------------------------------------------------------------------------
module tb_mca_list_mode_event_unpacker_top;

  localparam int unsigned NUM_CONV     = mlmeu_pkg::NUM_CONVERTERS_DEF;
  localparam int unsigned FLUSH_CYCLES = 4;
  localparam int unsigned END_CYCLES   = 10;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam longint unsigned LIMIT_NS = 5_000_000;

  localparam logic [mlmeu_pkg::WORD_W-1:0] DIRECTED [24] = '{
    32'hFFFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFE, 32'h0000_0000,
    32'h8000_0000, 32'h3FFF_0000, 32'h0000_0001, 32'h0000_7FFF,
    32'h8000_0001, 32'hABCD_1234,
    32'h8000_8001, 32'hFFFF_FFFF,
    32'h0000_FFFF, 32'h4000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h1234_5678, 32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_0001,
    32'h7FFF_FFFE,
    32'h8000_0007, 32'h1111_2222, 32'h3333_4444
  };

  // One unpacked result as seen on the output ports
  typedef struct packed {
    mlmeu_pkg::item_kind_e            kind;
    mlmeu_pkg::error_code_e           err;
    logic [mlmeu_pkg::IDX_W-1:0]      idx;
    logic [mlmeu_pkg::HALF_W-1:0]     value;
    logic [mlmeu_pkg::MULT_W-1:0]     mult;
    logic [mlmeu_pkg::CNT_W-1:0]      ticks;
    logic [mlmeu_pkg::CNT_W-1:0]      elapsed;
    logic                             last;
  } unpack_result_t;

  // Unpacker model and store of results still to come
  class unpack_scoreboard;
    logic [mlmeu_pkg::ACT_W-1:0]    active;
    logic [mlmeu_pkg::DSCALE_W-1:0] downscale;
    logic                           low_first;
    logic                           in_event;
    logic [mlmeu_pkg::HALF_W-1:0]   pending;
    logic                           skip_half;
    logic [mlmeu_pkg::MULT_W-1:0]   mult;
    logic [mlmeu_pkg::CNT_W-1:0]    ticks;
    logic [mlmeu_pkg::CNT_W-1:0]    elapsed;
    unpack_result_t                 awaited[$];
    int unsigned                    failures;

    function new();
      active    = mlmeu_pkg::ACTIVE_RESET;
      downscale = mlmeu_pkg::DOWNSCALE_RESET;
      low_first = 1'b1;
      in_event  = 1'b0;
      pending   = '0;
      skip_half = 1'b0;
      mult      = '0;
      ticks     = '0;
      elapsed   = '0;
      failures  = 0;
    endfunction

    function void note_config(logic [mlmeu_pkg::CFG_IDX_W-1:0] idx,
                              logic [mlmeu_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mlmeu_pkg::CFG_ACTIVE_CONVERTERS: active = data[mlmeu_pkg::ACT_W-1:0];
        mlmeu_pkg::CFG_TIMER_DOWNSCALE:   downscale = data[mlmeu_pkg::DSCALE_W-1:0];
        mlmeu_pkg::CFG_LOW_HALF_FIRST:    low_first = data[0];
        default: ;
      endcase
    endfunction

    // Converter bits of a header that count under the current setting
    function logic [mlmeu_pkg::HALF_W-1:0] used_bits();
      int unsigned act;
      act = (active > NUM_CONV) ? NUM_CONV : active;
      return mlmeu_pkg::HALF_W'((32'h1 << act) - 1);
    endfunction

    function void add(mlmeu_pkg::item_kind_e kind, mlmeu_pkg::error_code_e err,
                      logic [mlmeu_pkg::IDX_W-1:0] idx,
                      logic [mlmeu_pkg::HALF_W-1:0] value,
                      logic [mlmeu_pkg::MULT_W-1:0] m, logic last);
      unpack_result_t r;
      r.kind    = kind;
      r.err     = err;
      r.idx     = idx;
      r.value   = value;
      r.mult    = m;
      r.ticks   = ticks;
      r.elapsed = elapsed;
      r.last    = last;
      awaited.insert(awaited.size(), r);
    endfunction

    // Accepted stream word: advance the model and queue its results
    function void note_word(logic [mlmeu_pkg::WORD_W-1:0] w);
      logic [mlmeu_pkg::HALF_W-1:0] mask;
      logic [mlmeu_pkg::HALF_W-1:0] halves [2];
      int unsigned                  cnt;
      logic [mlmeu_pkg::IDX_W-1:0]  idx;
      logic                         last;
      if (!in_event) begin
        if (w == mlmeu_pkg::SYNC_WORD) begin
          add(mlmeu_pkg::KIND_SYNC, mlmeu_pkg::ERR_NO_TRIGGER, '0, '0, '0, 1'b0);
        end else if (w[mlmeu_pkg::TICK_BIT]) begin
          ticks   = ticks + 1;
          elapsed = elapsed + mlmeu_pkg::CNT_W'(downscale);
          add(mlmeu_pkg::KIND_TICK, mlmeu_pkg::ERR_NO_TRIGGER, '0, '0, '0, 1'b0);
        end else begin
          mask = w[mlmeu_pkg::HALF_W-1:0] & used_bits();
          cnt  = $countones(mask);
          if (cnt == 0) begin
            add(mlmeu_pkg::KIND_ERROR, mlmeu_pkg::ERR_NO_TRIGGER, '0, '0, '0, 1'b0);
          end else if (cnt[0] && !w[mlmeu_pkg::DUMMY_BIT]) begin
            add(mlmeu_pkg::KIND_ERROR, mlmeu_pkg::ERR_ODD_NO_DUMMY, '0, '0,
                mlmeu_pkg::MULT_W'(cnt), 1'b0);
          end else begin
            in_event  = 1'b1;
            pending   = mask;
            skip_half = cnt[0];
            mult      = mlmeu_pkg::MULT_W'(cnt);
          end
        end
        return;
      end
      halves[0] = low_first ? w[15:0] : w[31:16];
      halves[1] = low_first ? w[31:16] : w[15:0];
      for (int h = 0; h < 2; h++) begin
        if (!in_event) break;
        if (skip_half) begin
          skip_half = 1'b0;
          continue;
        end
        if (pending == '0) begin
          in_event = 1'b0;
          break;
        end
        idx = '0;
        for (int i = mlmeu_pkg::HALF_W - 1; i >= 0; i--) begin
          if (pending[i]) idx = mlmeu_pkg::IDX_W'(i);
        end
        pending[idx] = 1'b0;
        last = (pending == '0);
        add(mlmeu_pkg::KIND_VALUE, mlmeu_pkg::ERR_NO_TRIGGER, idx, halves[h], mult, last);
        if (last) in_event = 1'b0;
      end
    endfunction

    function void report(string field, logic [mlmeu_pkg::CNT_W-1:0] exp_val,
                         logic [mlmeu_pkg::CNT_W-1:0] got_val);
      failures++;
      if (failures <= MAX_REPORTS)
        $error("%s mismatch: expected %0h, actual %0h", field, exp_val, got_val);
    endfunction

    function void check_result(unpack_result_t got);
      unpack_result_t exp_r;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $error("result with nothing awaited: kind %0d value %0h", got.kind, got.value);
        return;
      end
      exp_r = awaited.pop_front();
      if (got.kind !== exp_r.kind)   report("item_kind", exp_r.kind, got.kind);
      if (got.err !== exp_r.err)     report("error_code", exp_r.err, got.err);
      if (got.idx !== exp_r.idx)     report("converter_index", exp_r.idx, got.idx);
      if (got.value !== exp_r.value) report("converter_value", exp_r.value, got.value);
      if (got.mult !== exp_r.mult)   report("event_multiplicity", exp_r.mult, got.mult);
      if (got.ticks !== exp_r.ticks) report("tick_count", exp_r.ticks, got.ticks);
      if (got.elapsed !== exp_r.elapsed)
        report("elapsed_ms", exp_r.elapsed, got.elapsed);
      if (got.last !== exp_r.last)   report("last_of_event", exp_r.last, got.last);
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             push;
  logic                             full;
  logic [mlmeu_pkg::WORD_W-1:0]     stream_word;
  logic                             cfg_we;
  logic [mlmeu_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mlmeu_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                             empty;
  logic                             pop;
  logic [1:0]                       item_kind;
  logic                             error_code;
  logic [mlmeu_pkg::IDX_W-1:0]      converter_index;
  logic [mlmeu_pkg::HALF_W-1:0]     converter_value;
  logic [mlmeu_pkg::MULT_W-1:0]     event_multiplicity;
  logic [mlmeu_pkg::CNT_W-1:0]      tick_count;
  logic [mlmeu_pkg::CNT_W-1:0]      elapsed_ms;
  logic                             last_of_event;

  unpack_scoreboard sb = new();

  bit          hold_req = 1'b0;
  int unsigned gap_max;
  int unsigned burst_max;
  int unsigned burst_left;
  int unsigned words_sent;

  mca_list_mode_event_unpacker_top u_dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .push                 (push),
    .full                 (full),
    .stream_word_i        (stream_word),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_data_i           (cfg_data),
    .empty                (empty),
    .pop                  (pop),
    .item_kind_o          (item_kind),
    .error_code_o         (error_code),
    .converter_index_o    (converter_index),
    .converter_value_o    (converter_value),
    .event_multiplicity_o (event_multiplicity),
    .tick_count_o         (tick_count),
    .elapsed_ms_o         (elapsed_ms),
    .last_of_event_o      (last_of_event)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Drop push, with junk on the data lines
  task automatic pause_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      push        <= 1'b0;
      stream_word <= $urandom;
    end
  endtask

  // Offer one word and hold it until the request is taken
  task automatic send_word(logic [mlmeu_pkg::WORD_W-1:0] w);
    @(negedge clk);
    push        <= 1'b1;
    stream_word <= w;
    do @(posedge clk); while (full);
    sb.note_word(w);
  endtask

  task automatic offer_word(logic [mlmeu_pkg::WORD_W-1:0] w);
    if (burst_left == 0) begin
      if (gap_max != 0) pause_sender($urandom_range(0, gap_max));
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    send_word(w);
    words_sent++;
  endtask

  task automatic write_reg(logic [mlmeu_pkg::CFG_IDX_W-1:0] idx,
                           logic [mlmeu_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Hold the sender until every awaited result is out, then let the pipe empty
  task automatic settle();
    pause_sender(1);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [mlmeu_pkg::WORD_W-1:0] make_header(
      logic [mlmeu_pkg::HALF_W-1:0] mask, logic [mlmeu_pkg::HALF_W-1:0] amask,
      logic dummy);
    logic [mlmeu_pkg::WORD_W-1:0] w;
    w                       = $urandom;
    w[mlmeu_pkg::DUMMY_BIT] = dummy;
    w[mlmeu_pkg::TICK_BIT]  = 1'b0;
    w[15:0]                 = (w[15:0] & ~amask) | mask;
    return w;
  endfunction

  // Payload word, sometimes shaped like a sync mark or a tick
  function automatic logic [mlmeu_pkg::WORD_W-1:0] data_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return mlmeu_pkg::SYNC_WORD;
    if (pick == 1) return {2'b01, 30'($urandom)};
    return $urandom;
  endfunction

  // One stream record: tick, sync, noise, broken header or a whole event
  task automatic send_record();
    logic [mlmeu_pkg::HALF_W-1:0] amask;
    logic [mlmeu_pkg::HALF_W-1:0] mask;
    logic [mlmeu_pkg::WORD_W-1:0] w;
    int unsigned                  pick;
    logic                         dummy;
    while (sb.in_event) offer_word(data_word());
    amask = sb.used_bits();
    pick  = $urandom_range(0, 99);
    if (pick < 12) begin
      w                      = $urandom;
      w[mlmeu_pkg::TICK_BIT] = 1'b1;
      offer_word(w);
    end else if (pick < 17) begin
      offer_word(mlmeu_pkg::SYNC_WORD);
    end else if (pick < 25) begin
      offer_word($urandom);
    end else if (pick < 32 || amask == '0) begin
      if (amask == '0 || $urandom_range(0, 1) == 0) begin
        offer_word(make_header('0, amask, 1'($urandom_range(0, 1))));
      end else begin
        mask = 16'($urandom) & amask;
        if ($countones(mask) % 2 == 0) mask[0] = ~mask[0];
        offer_word(make_header(mask, amask, 1'b0));
      end
    end else begin
      mask = 16'($urandom) & amask;
      if ($urandom_range(0, 7) == 0) mask = amask;
      if (mask == '0) mask = 16'h1 << $urandom_range(0, $countones(amask) - 1);
      dummy = ($countones(mask) % 2 == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      offer_word(make_header(mask, amask, dummy));
      repeat (($countones(mask) + 1) / 2) offer_word(data_word());
    end
  endtask

  task automatic run_phase(logic [mlmeu_pkg::CFG_DATA_W-1:0] active,
                           logic [mlmeu_pkg::CFG_DATA_W-1:0] downscale,
                           logic low_first, int unsigned target, int unsigned gaps,
                           int unsigned bursts, bit hold);
    settle();
    write_reg(mlmeu_pkg::CFG_ACTIVE_CONVERTERS, active);
    write_reg(mlmeu_pkg::CFG_TIMER_DOWNSCALE, downscale);
    write_reg(mlmeu_pkg::CFG_LOW_HALF_FIRST, mlmeu_pkg::CFG_DATA_W'(low_first));
    gap_max    = gaps;
    burst_max  = bursts;
    words_sent = 0;
    if (hold) hold_req = 1'b1;
    while (words_sent < target) send_record();
  endtask

  // Result side: check each popped result, then pick the next pop
  initial begin
    int unsigned    mode;
    int unsigned    mode_left;
    int unsigned    hold_left;
    int unsigned    cyc;
    unpack_result_t got;
    pop       = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    cyc       = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        got.kind    = mlmeu_pkg::item_kind_e'(item_kind);
        got.err     = mlmeu_pkg::error_code_e'(error_code);
        got.idx     = converter_index;
        got.value   = converter_value;
        got.mult    = event_multiplicity;
        got.ticks   = tick_count;
        got.elapsed = elapsed_ms;
        got.last    = last_of_event;
        sb.check_result(got);
      end
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!rst_n) begin
        pop <= 1'b0;
      end else begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (cyc % 5 < 3);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    rst_n       = 1'b0;
    push        = 1'b0;
    stream_word = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    gap_max     = 3;
    burst_max   = 4;
    burst_left  = 0;
    words_sent  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Headers, ticks, syncs, errors and short events under reset settings
    foreach (DIRECTED[i]) offer_word(DIRECTED[i]);

    // Full width, upper half first, no sender gaps, long receiver hold-off
    run_phase(16, 16'hFFFF, 1'b0, 300, 0, 1, 1'b1);
    // Oversized converter count saturates; zero downscale
    run_phase(16'h001F, 16'h0000, 1'b1, 250, 6, 12, 1'b0);
    // No converters: every data header is an error
    run_phase(0, 16'($urandom_range(1, 65534)), 1'b0, 150, 4, 20, 1'b0);
    run_phase(1, 16'($urandom), 1'b1, 300, 8, 30, 1'b0);
    run_phase(16'($urandom_range(2, 15)), 16'($urandom), 1'($urandom_range(0, 1)),
              350, 5, 16, 1'b0);
    run_phase(16, 1, 1'b1, 350, 2, 40, 1'b0);

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
src/mlmeu_pkg.sv
src/mlmeu_front.sv
src/mlmeu_queue.sv
src/mlmeu_back.sv
src/mca_list_mode_event_unpacker_top.sv
src/mlmeu_checker.sv
sim/tb_mca_list_mode_event_unpacker_top.sv
